// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Needs a clk and a rst signal in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst is high.
`define CHECK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clk edge, also during reset.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/tmmt_pkg.sv -----
// Package for the top-k min/max tracker: sizes, command codes and beat structs.
// No dependencies.
package tmmt_pkg;

  localparam int MAX_BEST    = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int POS_BITS    = 32;
  localparam int RANK_BITS   = 5;
  localparam int CFG_BITS    = 5;
  localparam int COUNT_BITS  = $clog2(MAX_BEST + 1);

  localparam logic [1:0] CMD_ACCUM = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                    command;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [RANK_BITS-1:0]          rank;
  } in_item_t;

  typedef struct packed {
    logic                          ok;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic [POS_BITS-1:0]           min_position;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [POS_BITS-1:0]           max_position;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [POS_BITS-1:0]           position;
  } entry_t;

  // per-cell control decoded from held count and rank
  typedef struct packed {
    logic active;
    logic last;
    logic pick;
  } cell_ctl_t;

  // handed from a cell to its right neighbor
  typedef struct packed {
    entry_t lo;
    entry_t hi;
    logic   ins_lo;
    logic   ins_hi;
  } link_t;

  // masked status, OR-reduced over the row
  typedef struct packed {
    logic   lt_lo;
    logic   gt_hi;
    entry_t q_lo;
    entry_t q_hi;
  } cell_stat_t;

endpackage

// ----- design/tmmt_cell.sv -----
// One rank slot of the tracker: holds the min-list and max-list entries of that rank.
// Depends on tmmt_pkg.
module tmmt_cell import tmmt_pkg::*; (
  input  logic                          clk,
  input  cell_ctl_t                     ctl,
  input  logic                          en_lo,
  input  logic                          en_hi,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [POS_BITS-1:0]           pos_in,
  input  link_t                         prev,
  output link_t                         link,
  output cell_stat_t                    stat
);

  entry_t lo;
  entry_t hi;
  entry_t fresh;
  logic   ins_lo;
  logic   ins_hi;
  logic   lt_lo;
  logic   gt_hi;

  always_comb begin
    fresh.value    = sample;
    fresh.position = pos_in;
    // newer sample goes ahead of equal values; empty slots always take
    ins_lo = !ctl.active || ($signed(sample) <= $signed(lo.value));
    ins_hi = !ctl.active || ($signed(sample) >= $signed(hi.value));
    lt_lo  = $signed(sample) < $signed(lo.value);
    gt_hi  = $signed(sample) > $signed(hi.value);

    link.lo     = lo;
    link.hi     = hi;
    link.ins_lo = ins_lo;
    link.ins_hi = ins_hi;

    stat.lt_lo = ctl.last && lt_lo;
    stat.gt_hi = ctl.last && gt_hi;
    stat.q_lo  = ctl.pick ? lo : '0;
    stat.q_hi  = ctl.pick ? hi : '0;
  end

  always_ff @(posedge clk) begin
    if (en_lo) begin
      if (prev.ins_lo) begin
        lo <= prev.lo;
      end else if (ins_lo) begin
        lo <= fresh;
      end
    end
    if (en_hi) begin
      if (prev.ins_hi) begin
        hi <= prev.hi;
      end else if (ins_hi) begin
        hi <= fresh;
      end
    end
  end

endmodule

// ----- design/top_k_min_max_tracker.sv -----
// Top level of the top-k min/max tracker: row of rank cells, counters, output register.
// Depends on tmmt_pkg, tmmt_cell and assert_macros.svh.
//
//  channel   direction  handshake              beat
//  in        input      in_valid / in_stall    in_data   (in_item_t)
//  out       output     out_valid / out_stall  out_data  (out_item_t)
//  cfg       input      cfg_we                 cfg_wdata (best_count)
//
// One item per cycle while in_stall is low: each cell compares combinationally and shifts in its own register.
// The result is in the output register the cycle after acceptance.
// in_stall is high only while a result waits under out_stall.
// Reset empties both lists, zeroes the position counter, best_count = 1.
`include "assert_macros.svh"

module top_k_min_max_tracker import tmmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  logic [CFG_BITS-1:0]   best_count;
  logic [COUNT_BITS-1:0] held_count;
  logic [POS_BITS-1:0]   arrival_counter;

  logic                  accept;
  logic                  do_accum;
  logic                  grow;
  logic                  any_lt;
  logic                  any_gt;
  logic                  en_lo;
  logic                  en_hi;
  logic                  q_ok;
  logic [COUNT_BITS-1:0] k_eff;
  entry_t                q_lo;
  entry_t                q_hi;
  out_item_t             result;

  cell_ctl_t  ctl  [MAX_BEST];
  link_t      link [MAX_BEST];
  cell_stat_t stat [MAX_BEST];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (32'(best_count) > 32'(MAX_BEST)) begin
      k_eff = COUNT_BITS'(MAX_BEST);
    end else begin
      k_eff = COUNT_BITS'(best_count);
    end
    grow     = held_count < k_eff;
    do_accum = accept && (in_data.command == CMD_ACCUM) && (best_count != '0);
    q_ok     = (in_data.rank != '0) && (32'(in_data.rank) <= 32'(held_count));
  end

  for (genvar i = 0; i < MAX_BEST; i++) begin : g_cell
    link_t prev;

    always_comb begin
      ctl[i].active = 32'(held_count) > i;
      ctl[i].last   = 32'(held_count) == i + 1;
      ctl[i].pick   = q_ok && (32'(in_data.rank) == i + 1);
    end

    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = link[i-1];
    end

    tmmt_cell u_cell (
      .clk    (clk),
      .ctl    (ctl[i]),
      .en_lo  (en_lo),
      .en_hi  (en_hi),
      .sample (in_data.sample),
      .pos_in (arrival_counter),
      .prev   (prev),
      .link   (link[i]),
      .stat   (stat[i])
    );
  end

  always_comb begin
    any_lt = 1'b0;
    any_gt = 1'b0;
    q_lo   = '0;
    q_hi   = '0;
    for (int i = 0; i < MAX_BEST; i++) begin
      any_lt = any_lt | stat[i].lt_lo;
      any_gt = any_gt | stat[i].gt_hi;
      q_lo   = q_lo | stat[i].q_lo;
      q_hi   = q_hi | stat[i].q_hi;
    end
    en_lo = do_accum && (grow || any_lt);
    en_hi = do_accum && (grow || any_gt);
  end

  always_comb begin
    result              = '0;
    result.min_value    = q_lo.value;
    result.min_position = q_lo.position;
    result.max_value    = q_hi.value;
    result.max_position = q_hi.position;
    case (in_data.command)
      CMD_ACCUM: result.ok = best_count != '0;
      CMD_QUERY: result.ok = q_ok;
      CMD_CLEAR: result.ok = 1'b1;
      default:   result.ok = 1'b0;
    endcase
    if (in_data.command != CMD_QUERY) begin
      result.min_value    = '0;
      result.min_position = '0;
      result.max_value    = '0;
      result.max_position = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_count      <= CFG_BITS'(1);
      held_count      <= '0;
      arrival_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        best_count <= cfg_wdata;
      end
      if (accept && (in_data.command == CMD_CLEAR)) begin
        held_count      <= '0;
        arrival_counter <= '0;
      end else if (do_accum) begin
        if (grow) begin
          held_count <= held_count + COUNT_BITS'(1);
        end
        arrival_counter <= arrival_counter + POS_BITS'(1);
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  `CHECK_ALWAYS(a_held_bound, rst || (32'(held_count) <= 32'(MAX_BEST)),
    "held_count beyond list depth")
  `CHECK_CLK(a_accept_result, accept |=> out_valid,
    "accepted beat produced no result")
  `CHECK_CLK(a_clear_empties, accept && (in_data.command == CMD_CLEAR) |=>
    (held_count == '0) && (arrival_counter == '0), "clear left state behind")
  `CHECK_CLK(a_bad_rank, accept && (in_data.command == CMD_QUERY) &&
    (in_data.rank == '0) |=> !out_data.ok && (out_data.min_position == '0),
    "rank zero query reported data")

endmodule
